// ----- hw/rtl/servo_command_position_controller_core_assert.svh -----
// Assertion macros for the servo command position controller checker
`ifndef SERVO_COMMAND_POSITION_CONTROLLER_CORE_ASSERT_SVH
`define SERVO_COMMAND_POSITION_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define SCPC_AST_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define SCPC_AST_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/scpc_pkg.sv -----
// Types, constants and helper functions shared by the servo command controller
package scpc_pkg;

	localparam int NUM_SERVOS = 8;

	typedef logic [1:0]  level_t;
	typedef logic [15:0] pulse_t;
	typedef logic [2:0]  servo_idx_t;
	typedef logic [7:0]  key_t;
	typedef logic [1:0]  reg_idx_t;

	typedef enum logic [2:0] {
		MODE_IDLE      = 3'd0,
		MODE_MOVING    = 3'd1,
		MODE_LOCATING  = 3'd2,
		MODE_GRABBED   = 3'd3,
		MODE_NOT_FOUND = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		OP_NOP  = 3'd0,
		OP_TICK = 3'd1,
		OP_STEP = 3'd2,
		OP_HOME = 3'd3,
		OP_MODE = 3'd4
	} op_t;

	localparam reg_idx_t REG_PULSE_LOW    = 2'd0;
	localparam reg_idx_t REG_PULSE_CENTER = 2'd1;
	localparam reg_idx_t REG_PULSE_HIGH   = 2'd2;

	localparam pulse_t RST_PULSE_LOW    = 16'd6000;
	localparam pulse_t RST_PULSE_CENTER = 16'd9000;
	localparam pulse_t RST_PULSE_HIGH   = 16'd12000;

	localparam level_t LVL_LOW = 2'd0;
	localparam level_t LVL_MID = 2'd1;
	localparam level_t LVL_TOP = 2'd2;

	localparam key_t KEY_UP_FIRST = 8'h31;
	localparam key_t KEY_UP_LAST  = 8'h38;
	localparam key_t KEY_HOME     = 8'h68;
	localparam key_t KEY_LOCATE   = 8'h6C;
	localparam key_t KEY_GRAB     = 8'h67;
	localparam key_t KEY_NOTFOUND = 8'h6E;

	localparam servo_idx_t LINK_DRIVER   = 3'd4;
	localparam servo_idx_t LINK_FOLLOWER = 3'd5;
	localparam servo_idx_t LINK_LEADER   = 3'd6;

	typedef struct packed {
		op_t        op;
		servo_idx_t servo;
		logic       up;
		mode_t      mode;
	} cmd_t;

	typedef struct packed {
		level_t [NUM_SERVOS-1:0] lvl;
		mode_t                   mode;
		logic                    recog;
	} res_t;

	function automatic key_t down_key(input servo_idx_t idx);
		key_t k;
		case (idx)
			3'd0: k = 8'h71;
			3'd1: k = 8'h77;
			3'd2: k = 8'h65;
			3'd3: k = 8'h72;
			3'd4: k = 8'h74;
			3'd5: k = 8'h79;
			3'd6: k = 8'h75;
			3'd7: k = 8'h69;
			default: k = 8'h00;
		endcase
		return k;
	endfunction

	function automatic pulse_t level_pulse(input level_t lv, input pulse_t lo,
		input pulse_t ce, input pulse_t hi);
		pulse_t p;
		case (lv)
			LVL_LOW: p = lo;
			LVL_MID: p = ce;
			default: p = hi;
		endcase
		return p;
	endfunction

endpackage

// ----- hw/rtl/scpc_fifo.sv -----
// Small register queue used between the front, the back and the result port
module scpc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic do_push, do_pop;

	assign full    = (cnt_q == CNT_FULL);
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule

// ----- hw/rtl/scpc_decode.sv -----
// Front end: classify an incoming byte or tick into a command
module scpc_decode import scpc_pkg::*; (
	input  logic       kind,
	input  logic [7:0] cmd_byte,
	output cmd_t       cmd
);
	always_comb begin
		cmd.op    = OP_NOP;
		cmd.servo = '0;
		cmd.up    = 1'b0;
		cmd.mode  = MODE_IDLE;
		if (kind) begin
			cmd.op = OP_TICK;
		end else if (cmd_byte >= KEY_UP_FIRST && cmd_byte <= KEY_UP_LAST) begin
			cmd.op    = OP_STEP;
			cmd.servo = servo_idx_t'(cmd_byte - KEY_UP_FIRST);
			cmd.up    = 1'b1;
		end else if (cmd_byte == KEY_HOME) begin
			cmd.op = OP_HOME;
		end else if (cmd_byte == KEY_LOCATE) begin
			cmd.op   = OP_MODE;
			cmd.mode = MODE_LOCATING;
		end else if (cmd_byte == KEY_GRAB) begin
			cmd.op   = OP_MODE;
			cmd.mode = MODE_GRABBED;
		end else if (cmd_byte == KEY_NOTFOUND) begin
			cmd.op   = OP_MODE;
			cmd.mode = MODE_NOT_FOUND;
		end else begin
			for (int i = 0; i < NUM_SERVOS; i++) begin
				if (cmd_byte == down_key(servo_idx_t'(i))) begin
					cmd.op    = OP_STEP;
					cmd.servo = servo_idx_t'(i);
				end
			end
		end
	end
endmodule

// ----- hw/rtl/scpc_exec.sv -----
// Back end: apply commands to the servo levels and arm mode
module scpc_exec import scpc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_pop,
	input  logic res_full,
	output logic res_push,
	output res_t res
);
	level_t [NUM_SERVOS-1:0] lvl_q, lvl_d;
	mode_t mode_q, mode_d;
	logic [NUM_SERVOS-1:0] up_s, dn_s;
	logic fire;

	assign fire     = cmd_valid && !res_full;
	assign cmd_pop  = fire;
	assign res_push = fire;

	always_comb begin
		up_s = '0;
		dn_s = '0;
		if (cmd.op == OP_STEP) begin
			up_s[cmd.servo] = cmd.up;
			dn_s[cmd.servo] = !cmd.up;
			if (cmd.servo == LINK_LEADER) begin
				up_s[LINK_FOLLOWER] = cmd.up;
				dn_s[LINK_FOLLOWER] = !cmd.up;
			end
			if (cmd.servo == LINK_DRIVER) begin
				up_s[LINK_FOLLOWER] = !cmd.up;
				dn_s[LINK_FOLLOWER] = cmd.up;
				up_s[LINK_LEADER]   = !cmd.up;
				dn_s[LINK_LEADER]   = cmd.up;
			end
		end
		for (int i = 0; i < NUM_SERVOS; i++) begin
			if (cmd.op == OP_HOME) begin
				lvl_d[i] = LVL_MID;
			end else if (up_s[i] && lvl_q[i] < LVL_TOP) begin
				lvl_d[i] = lvl_q[i] + 1'b1;
			end else if (dn_s[i] && lvl_q[i] != LVL_LOW) begin
				lvl_d[i] = lvl_q[i] - 1'b1;
			end else begin
				lvl_d[i] = lvl_q[i];
			end
		end
	end

	always_comb begin
		case (cmd.op)
			OP_TICK: mode_d = (mode_q == MODE_MOVING) ? MODE_IDLE : mode_q;
			OP_STEP: mode_d = MODE_MOVING;
			OP_HOME: mode_d = MODE_IDLE;
			OP_MODE: mode_d = cmd.mode;
			default: mode_d = mode_q;
		endcase
		res.lvl   = lvl_d;
		res.mode  = mode_d;
		res.recog = (cmd.op == OP_STEP) || (cmd.op == OP_HOME) || (cmd.op == OP_MODE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_SERVOS; i++) begin
				lvl_q[i] <= LVL_MID;
			end
			mode_q <= MODE_IDLE;
		end else if (fire) begin
			lvl_q  <= lvl_d;
			mode_q <= mode_d;
		end
	end
endmodule

// ----- hw/rtl/servo_command_position_controller_core.sv -----
// Top level of the servo command position controller
//
//  channel  | handshake         | payload
//  ---------+-------------------+------------------------------------------
//  input    | push / full       | kind, cmd_byte
//  result   | empty / pop       | servo1_pulse..servo8_pulse, arm_mode,
//           |                   | recognized
//  config   | cfg_valid / ready | cfg_index, cfg_data
//
// One item per cycle sustained while results are popped; each passes both registered queues.
// The command queue feeds the execute stage, which writes the result queue.
// Pulse counts are mapped from stored levels at the result port with the current registers.
// Reset: all servos at the middle level, mode idle, both queues empty; cfg_ready is always high.
// A stalled result port fills the result queue, then the command queue, then raises full.
module servo_command_position_controller_core import scpc_pkg::*; #(
	parameter int CMD_DEPTH = 2,
	parameter int RES_DEPTH = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        kind,
	input  logic [7:0]  cmd_byte,
	output logic        empty,
	input  logic        pop,
	output logic [15:0] servo1_pulse,
	output logic [15:0] servo2_pulse,
	output logic [15:0] servo3_pulse,
	output logic [15:0] servo4_pulse,
	output logic [15:0] servo5_pulse,
	output logic [15:0] servo6_pulse,
	output logic [15:0] servo7_pulse,
	output logic [15:0] servo8_pulse,
	output logic [2:0]  arm_mode,
	output logic        recognized,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	localparam int CMD_W = $bits(cmd_t);
	localparam int RES_W = $bits(res_t);

	pulse_t pulse_low_q, pulse_center_q, pulse_high_q;
	cmd_t cmd_in, cmd_head;
	res_t res_in, res_head;
	logic [CMD_W-1:0] cmd_head_bits;
	logic [RES_W-1:0] res_head_bits;
	logic cmd_empty, cmd_pop, res_full, res_push;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_low_q    <= RST_PULSE_LOW;
			pulse_center_q <= RST_PULSE_CENTER;
			pulse_high_q   <= RST_PULSE_HIGH;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PULSE_LOW:    pulse_low_q    <= cfg_data;
				REG_PULSE_CENTER: pulse_center_q <= cfg_data;
				REG_PULSE_HIGH:   pulse_high_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	scpc_decode u_decode (
		.kind     (kind),
		.cmd_byte (cmd_byte),
		.cmd      (cmd_in)
	);

	scpc_fifo #(.WIDTH(CMD_W), .DEPTH(CMD_DEPTH)) u_cmd_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (CMD_W'(cmd_in)),
		.full   (full),
		.pop    (cmd_pop),
		.dout   (cmd_head_bits),
		.empty  (cmd_empty)
	);

	assign cmd_head = cmd_t'(cmd_head_bits);

	scpc_exec u_exec (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!cmd_empty),
		.cmd       (cmd_head),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (res_in)
	);

	scpc_fifo #(.WIDTH(RES_W), .DEPTH(RES_DEPTH)) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (RES_W'(res_in)),
		.full   (res_full),
		.pop    (pop),
		.dout   (res_head_bits),
		.empty  (empty)
	);

	assign res_head = res_t'(res_head_bits);

	assign servo1_pulse = level_pulse(res_head.lvl[0], pulse_low_q, pulse_center_q, pulse_high_q);
	assign servo2_pulse = level_pulse(res_head.lvl[1], pulse_low_q, pulse_center_q, pulse_high_q);
	assign servo3_pulse = level_pulse(res_head.lvl[2], pulse_low_q, pulse_center_q, pulse_high_q);
	assign servo4_pulse = level_pulse(res_head.lvl[3], pulse_low_q, pulse_center_q, pulse_high_q);
	assign servo5_pulse = level_pulse(res_head.lvl[4], pulse_low_q, pulse_center_q, pulse_high_q);
	assign servo6_pulse = level_pulse(res_head.lvl[5], pulse_low_q, pulse_center_q, pulse_high_q);
	assign servo7_pulse = level_pulse(res_head.lvl[6], pulse_low_q, pulse_center_q, pulse_high_q);
	assign servo8_pulse = level_pulse(res_head.lvl[7], pulse_low_q, pulse_center_q, pulse_high_q);
	assign arm_mode     = 3'(res_head.mode);
	assign recognized   = res_head.recog;
endmodule

// ----- hw/rtl/scpc_checker.sv -----
// Port-level checker for the servo command position controller, with its bind
`include "servo_command_position_controller_core_assert.svh"

module scpc_checker import scpc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [15:0] servo1_pulse,
	input logic [15:0] servo4_pulse,
	input logic [15:0] servo5_pulse,
	input logic [15:0] servo6_pulse,
	input logic [15:0] servo7_pulse,
	input logic [15:0] servo8_pulse,
	input logic [2:0]  arm_mode,
	input logic        recognized,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [1:0]  cfg_index,
	input logic [15:0] cfg_data
);
	pulse_t lo_q, ce_q, hi_q;
	logic home_shown, stalled;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q <= RST_PULSE_LOW;
			ce_q <= RST_PULSE_CENTER;
			hi_q <= RST_PULSE_HIGH;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PULSE_LOW:    lo_q <= cfg_data;
				REG_PULSE_CENTER: ce_q <= cfg_data;
				REG_PULSE_HIGH:   hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign home_shown = !empty && recognized && (arm_mode == MODE_IDLE);
	assign stalled    = !empty && !pop && !(cfg_valid && cfg_ready);

	`SCPC_AST_NXT(a_result_holds, stalled, !empty && $stable(recognized) && $stable(arm_mode) && $stable(servo5_pulse), "result changed while stalled")
	`SCPC_AST_IMP(a_servo1_level, !empty, servo1_pulse == lo_q || servo1_pulse == ce_q || servo1_pulse == hi_q, "servo 1 pulse off the level set")
	`SCPC_AST_IMP(a_servo7_level, !empty, servo7_pulse == lo_q || servo7_pulse == ce_q || servo7_pulse == hi_q, "servo 7 pulse off the level set")
	`SCPC_AST_IMP(a_home_center, home_shown, servo1_pulse == ce_q && servo4_pulse == ce_q && servo6_pulse == ce_q && servo8_pulse == ce_q, "home result not at center")
endmodule

bind servo_command_position_controller_core scpc_checker u_scpc_checker (.*);
